// ===== rtl/caf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caf_pkg
// Shared types, constants and tables of the complementary attitude filter.
// ----------------------------------------------------------------------------
package caf_pkg;

  localparam int CordicSteps = 16;
  localparam int AngleFracBits = 16;
  localparam int CnW = 5;

  // CORDIC datapath: 16-bit operand scaled by 2^24 plus growth headroom.
  localparam int CW = 44;
  localparam int ZW = 33;

  localparam logic [31:0] BlendReset = 32'd62415;
  localparam logic [31:0] TiltReset = 32'd1310740;
  localparam logic [31:0] HeadReset = 32'd3827361;
  localparam logic signed [ZW-1:0] Deg90 = 33'sd1509949440;

  localparam logic [1:0] REG_BLEND = 2'd0;
  localparam logic [1:0] REG_TILT = 2'd1;
  localparam logic [1:0] REG_HEAD = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROLL_INIT,
    ST_ROLL_ITER,
    ST_ROLL_DONE,
    ST_PITCH_INIT,
    ST_PITCH_ITER,
    ST_PITCH_DONE,
    ST_MUL_ROLL,
    ST_MUL_PITCH,
    ST_MUL_YAW,
    ST_BLEND_ROLL,
    ST_BLEND_PITCH,
    ST_OUT
  } caf_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CORDIC_INIT,
    OP_CORDIC_ITER,
    OP_INTEGRATE,
    OP_BLEND,
    OP_OUT
  } caf_op_t;

  typedef struct packed {
    caf_op_t op;
    logic [1:0] sel;
    logic load;
  } caf_cmd_t;

  typedef struct packed {
    logic iter_last;
  } caf_stat_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [CnW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0: v = 33'sd754974720;
      5'd1: v = 33'sd445687602;
      5'd2: v = 33'sd235489088;
      5'd3: v = 33'sd119537938;
      5'd4: v = 33'sd60000934;
      5'd5: v = 33'sd30029717;
      5'd6: v = 33'sd15018523;
      5'd7: v = 33'sd7509720;
      5'd8: v = 33'sd3754917;
      5'd9: v = 33'sd1877466;
      5'd10: v = 33'sd938734;
      5'd11: v = 33'sd469367;
      5'd12: v = 33'sd234684;
      5'd13: v = 33'sd117342;
      5'd14: v = 33'sd58671;
      5'd15: v = 33'sd29335;
      5'd16: v = 33'sd14668;
      5'd17: v = 33'sd7334;
      5'd18: v = 33'sd3667;
      5'd19: v = 33'sd1833;
      5'd20: v = 33'sd917;
      5'd21: v = 33'sd458;
      5'd22: v = 33'sd229;
      5'd23: v = 33'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7fffffff;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/caf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caf_sample_if / caf_angle_if
// Valid/ready channels for the raw sample and for the angle result.
// ----------------------------------------------------------------------------
interface caf_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  modport source(output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                 input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
               output ready);
endinterface

interface caf_angle_if;
  logic valid;
  logic ready;
  logic signed [31:0] roll_out;
  logic signed [31:0] pitch_out;
  logic signed [31:0] yaw_out;
  modport source(output valid, roll_out, pitch_out, yaw_out, input ready);
  modport sink(input valid, roll_out, pitch_out, yaw_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/caf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caf_ctrl
// Sequencer: two CORDIC runs, three gain multiplies, two blends, output.
// ----------------------------------------------------------------------------
module caf_ctrl import caf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_fire,
  input  wire logic      out_free,
  input  caf_stat_t      stat,
  output caf_cmd_t       cmd,
  output logic           busy
);

  caf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:        if (in_fire) state_nxt = ST_ROLL_INIT;
      ST_ROLL_INIT:   state_nxt = ST_ROLL_ITER;
      ST_ROLL_ITER:   if (stat.iter_last) state_nxt = ST_ROLL_DONE;
      ST_ROLL_DONE:   state_nxt = ST_PITCH_INIT;
      ST_PITCH_INIT:  state_nxt = ST_PITCH_ITER;
      ST_PITCH_ITER:  if (stat.iter_last) state_nxt = ST_PITCH_DONE;
      ST_PITCH_DONE:  state_nxt = ST_MUL_ROLL;
      ST_MUL_ROLL:    state_nxt = ST_MUL_PITCH;
      ST_MUL_PITCH:   state_nxt = ST_MUL_YAW;
      ST_MUL_YAW:     state_nxt = ST_BLEND_ROLL;
      ST_BLEND_ROLL:  state_nxt = ST_BLEND_PITCH;
      ST_BLEND_PITCH: state_nxt = ST_OUT;
      ST_OUT:         if (out_free) state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: OP_NONE, sel: 2'd0, load: 1'b0};
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      ST_ROLL_INIT:   cmd = '{op: OP_CORDIC_INIT, sel: 2'd0, load: 1'b0};
      ST_ROLL_ITER:   cmd = '{op: OP_CORDIC_ITER, sel: 2'd0, load: 1'b0};
      ST_ROLL_DONE:   cmd = '{op: OP_NONE, sel: 2'd0, load: 1'b0};
      ST_PITCH_INIT:  cmd = '{op: OP_CORDIC_INIT, sel: 2'd1, load: 1'b0};
      ST_PITCH_ITER:  cmd = '{op: OP_CORDIC_ITER, sel: 2'd1, load: 1'b0};
      ST_PITCH_DONE:  cmd = '{op: OP_NONE, sel: 2'd1, load: 1'b0};
      ST_MUL_ROLL:    cmd = '{op: OP_INTEGRATE, sel: 2'd0, load: 1'b0};
      ST_MUL_PITCH:   cmd = '{op: OP_INTEGRATE, sel: 2'd1, load: 1'b0};
      ST_MUL_YAW:     cmd = '{op: OP_INTEGRATE, sel: 2'd2, load: 1'b0};
      ST_BLEND_ROLL:  cmd = '{op: OP_BLEND, sel: 2'd0, load: 1'b0};
      ST_BLEND_PITCH: cmd = '{op: OP_BLEND, sel: 2'd1, load: 1'b0};
      ST_OUT:         cmd = '{op: out_free ? OP_OUT : OP_NONE, sel: 2'd0, load: 1'b0};
      default:        cmd = '{op: OP_NONE, sel: 2'd0, load: 1'b0};
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/caf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caf_datapath
// Sample registers, a shared CORDIC vectoring stage, a shared gain multiplier,
// the blend multipliers and the angle state registers.
// ----------------------------------------------------------------------------
module caf_datapath import caf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  caf_cmd_t                cmd,
  output caf_stat_t               stat,
  input  wire logic signed [15:0] ax_in,
  input  wire logic signed [15:0] ay_in,
  input  wire logic signed [15:0] az_in,
  input  wire logic signed [15:0] gx_in,
  input  wire logic signed [15:0] gy_in,
  input  wire logic signed [15:0] gz_in,
  input  wire logic [15:0]        blend_w,
  input  wire logic [23:0]        tilt_gain,
  input  wire logic [23:0]        head_gain,
  output logic signed [31:0]      roll_q,
  output logic signed [31:0]      pitch_q,
  output logic signed [31:0]      yaw_q
);

  localparam int RoundSh = 24 - AngleFracBits;
  localparam int GyroSh = 32 - AngleFracBits;

  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic [CnW-1:0] it_r;
  logic zero_r;
  logic signed [31:0] roll_acc_r, pitch_acc_r;
  logic signed [31:0] roll_g_r, pitch_g_r;
  logic signed [31:0] roll_r, pitch_r, yaw_r;

  // CORDIC init operands.
  logic signed [15:0] y0, x0;
  logic signed [CW-1:0] xs, ys, xi, yi;
  logic signed [ZW-1:0] zi;
  always_comb begin
    y0 = (cmd.sel == 2'd0) ? ay_r : ax_r;
    x0 = az_r;
    xs = CW'(y0 - 16'sd0) ;
    xs = {{(CW-40){x0[15]}}, x0, 24'd0};
    ys = {{(CW-40){y0[15]}}, y0, 24'd0};
    xi = xs; yi = ys; zi = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        xi = ys; yi = -xs; zi = Deg90;
      end else begin
        xi = -ys; yi = xs; zi = -Deg90;
      end
    end
  end

  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  logic signed [ZW-1:0] zr;
  logic signed [31:0] tilt;
  always_comb begin
    dx = cy_r >>> it_r;
    dy = cx_r >>> it_r;
    at = atan_lut(it_r);
    zr = (cz_r + (ZW'(1) <<< (RoundSh - 1))) >>> RoundSh;
    tilt = zero_r ? 32'sd0 : 32'(zr);
    stat.iter_last = (it_r == CnW'(CordicSteps - 1));
  end

  // Multipliers: rate times gain, shared by the three axes, and the two blend products.
  logic signed [16:0] ma;
  logic signed [24:0] mb;
  logic signed [41:0] prod;
  logic signed [31:0] ang, rate_ang;
  logic signed [49:0] incr, isum;
  logic signed [31:0] gpath, apath;
  logic signed [49:0] bsum;
  logic signed [49:0] bprod_g, bprod_a;
  always_comb begin
    case (cmd.sel)
      2'd0: begin ma = 17'(gx_r); mb = {1'b0, tilt_gain}; ang = roll_r; end
      2'd1: begin ma = 17'(gy_r); mb = {1'b0, tilt_gain}; ang = pitch_r; end
      default: begin ma = 17'(gz_r); mb = {1'b0, head_gain}; ang = yaw_r; end
    endcase
    prod = 42'(ma) * 42'(mb);
    incr = (50'(prod) + (50'sd1 <<< (GyroSh - 1))) >>> GyroSh;
    isum = 50'(ang) + incr;
    rate_ang = sat32(isum);
    gpath = (cmd.sel == 2'd0) ? roll_g_r : pitch_g_r;
    apath = (cmd.sel == 2'd0) ? roll_acc_r : pitch_acc_r;
    bprod_g = 50'($signed({1'b0, blend_w})) * 50'(gpath);
    bprod_a = (50'sd65536 - 50'($signed({1'b0, blend_w}))) * 50'(apath);
    bsum = (bprod_g + bprod_a + 50'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r <= '0;
      pitch_r <= '0;
      yaw_r <= '0;
    end else begin
      case (cmd.op)
        OP_INTEGRATE: begin
          case (cmd.sel)
            2'd0: roll_g_r <= rate_ang;
            2'd1: pitch_g_r <= rate_ang;
            default: yaw_r <= rate_ang;
          endcase
        end
        OP_BLEND: begin
          if (cmd.sel == 2'd0) roll_r <= sat32(bsum);
          else pitch_r <= sat32(bsum);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= ax_in; ay_r <= ay_in; az_r <= az_in;
      gx_r <= gx_in; gy_r <= gy_in; gz_r <= gz_in;
    end
    case (cmd.op)
      OP_CORDIC_INIT: begin
        cx_r <= xi; cy_r <= yi; cz_r <= zi; it_r <= '0;
        zero_r <= (x0 == 16'sd0) && (y0 == 16'sd0);
      end
      OP_CORDIC_ITER: begin
        it_r <= it_r + CnW'(1);
        if (cy_r >= 0) begin
          cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + at;
        end else begin
          cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - at;
        end
      end
      default: ;
    endcase
    // The finished tilt is captured right after the last iteration.
    if (cmd.op == OP_NONE && !cmd.load) begin
      if (cmd.sel == 2'd0) roll_acc_r <= tilt;
      else if (cmd.sel == 2'd1) pitch_acc_r <= -tilt;
    end
  end

  assign roll_q = roll_r;
  assign pitch_q = pitch_r;
  assign yaw_q = yaw_r;

endmodule
`default_nettype wire

// ===== rtl/complementary_attitude_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// complementary_attitude_filter
// Roll/pitch/yaw complementary filter with CORDIC tilt from the accelerometer.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_      sink       accel_x/y/z, rate_x/y/z (signed 16 bit)
//  out_     source     roll_out, pitch_out, yaw_out (signed Q15.16)
//  cfg_     write      blend_weight, tilt_rate_gain, heading_rate_gain
//
// The result becomes valid after its request is accepted and two CORDIC
// runs (load, 16 steps, capture) on one shared vectoring stage, then three
// gain multiplies and two blends. The next request is taken the cycle after
// the result is taken. Reset is synchronous; it clears the angles and loads
// the default configuration registers.
// The result holds until taken; input stays stalled while it waits.
module complementary_attitude_filter import caf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  caf_sample_if.sink       in_ch,
  caf_angle_if.source      out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  logic [15:0] blend_r;
  logic [23:0] tilt_r, head_r;
  caf_cmd_t cmd;
  caf_stat_t stat;
  logic busy, in_fire;
  logic out_valid_r;
  logic signed [31:0] roll_q, pitch_q, yaw_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_r <= BlendReset[15:0];
      tilt_r <= TiltReset[23:0];
      head_r <= HeadReset[23:0];
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND: blend_r <= cfg_data[15:0];
        REG_TILT:  tilt_r <= cfg_data;
        REG_HEAD:  head_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_BLEND && cmd.sel == 2'd1) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  caf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_free(out_ch.ready), .stat(stat), .cmd(cmd), .busy(busy)
  );

  caf_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .ax_in(in_ch.accel_x), .ay_in(in_ch.accel_y), .az_in(in_ch.accel_z),
    .gx_in(in_ch.rate_x), .gy_in(in_ch.rate_y), .gz_in(in_ch.rate_z),
    .blend_w(blend_r), .tilt_gain(tilt_r), .head_gain(head_r),
    .roll_q(roll_q), .pitch_q(pitch_q), .yaw_q(yaw_q)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.roll_out = roll_q;
  assign out_ch.pitch_out = pitch_q;
  assign out_ch.yaw_out = yaw_q;

endmodule
`default_nettype wire

// ===== tb/tb_complementary_attitude_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complementary_attitude_filter
// Drives raw six-axis samples into the attitude filter with random bursts,
// gaps and output stalls, predicts roll, pitch and yaw from its own model of
// the CORDIC tilt, gyro integration and blend, and compares every result.
// ----------------------------------------------------------------------------
module tb_complementary_attitude_filter import caf_pkg::*;;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] roll, pitch, yaw;
  } attitude_t;

  typedef struct {
    sample_t s;
    bit has_exp;
    attitude_t exp;
  } row_t;

  localparam int LimitCycles = 1_000_000;
  localparam int RandomItems = 1200;
  localparam int DrainCycles = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  caf_sample_if in_ch ();
  caf_angle_if out_ch ();

  complementary_attitude_filter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state.
  logic signed [31:0] roll_q, pitch_q, yaw_q;
  logic [15:0] weight_q;
  logic [23:0] tilt_gain_q, head_gain_q;

  attitude_t pending_angles[$];
  int errors = 0;
  int cycles = 0;
  bit long_hold = 1'b0;

  function automatic longint tilt_table(int i);
    longint t[24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                      30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                      469367, 234684, 117342, 58671, 29335, 14668, 7334,
                      3667, 1833, 917, 458, 229, 115};
    return t[i];
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint tilt_atan2(longint yi, longint xi);
    longint x, y, z, dx, dy, t;
    x = xi <<< 24;
    y = yi <<< 24;
    z = 0;
    if (xi == 0 && yi == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 1509949440;
      end else begin
        x = -y; y = t; z = -1509949440;
      end
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += tilt_table(i);
      end else begin
        x -= dx; y += dy; z -= tilt_table(i);
      end
    end
    return rnd_shift(z, 24 - AngleFracBits);
  endfunction

  function automatic logic signed [31:0] gyro_step(logic signed [31:0] ang,
                                                  longint rate, longint gain);
    return clamp32(longint'(ang) + rnd_shift(rate * gain, 32 - AngleFracBits));
  endfunction

  function automatic logic signed [31:0] mix_tilt(logic signed [31:0] gyro_path,
                                                  longint acc_path);
    longint w;
    w = weight_q;
    return clamp32(rnd_shift(w * gyro_path + (65536 - w) * acc_path, 16));
  endfunction

  function automatic attitude_t update_attitude(sample_t s);
    longint r_acc, p_acc;
    logic signed [31:0] r_g, p_g;
    attitude_t a;
    r_acc = tilt_atan2(s.ay, s.az);
    p_acc = -tilt_atan2(s.ax, s.az);
    r_g = gyro_step(roll_q, s.gx, tilt_gain_q);
    p_g = gyro_step(pitch_q, s.gy, tilt_gain_q);
    yaw_q = gyro_step(yaw_q, s.gz, head_gain_q);
    roll_q = mix_tilt(r_g, r_acc);
    pitch_q = mix_tilt(p_g, p_acc);
    a.roll = roll_q;
    a.pitch = pitch_q;
    a.yaw = yaw_q;
    return a;
  endfunction

  // Result checking at the rising edge.
  always @(posedge clk) begin
    attitude_t e;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_angles.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = pending_angles.pop_front();
        if (out_ch.roll_out !== e.roll) begin
          $error("roll_out expected %0d actual %0d", e.roll, out_ch.roll_out);
          errors++;
        end
        if (out_ch.pitch_out !== e.pitch) begin
          $error("pitch_out expected %0d actual %0d", e.pitch, out_ch.pitch_out);
          errors++;
        end
        if (out_ch.yaw_out !== e.yaw) begin
          $error("yaw_out expected %0d actual %0d", e.yaw, out_ch.yaw_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LimitCycles) begin
      $display("tb_complementary_attitude_filter NOT OK");
      $finish;
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off when asked.
  initial begin
    int mode;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end
      mode = (cycles / 500) % 3;
      if (mode == 0) out_ch.ready <= 1'b1;
      else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLEND: weight_q = val[15:0];
      REG_TILT: tilt_gain_q = val;
      REG_HEAD: head_gain_q = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Called at a falling edge; returns at a falling edge with valid still high
  // so that back-to-back requests never lower it within one step.
  task automatic send_sample(sample_t s);
    in_ch.valid <= 1'b1;
    {in_ch.accel_x, in_ch.accel_y, in_ch.accel_z} <= {s.ax, s.ay, s.az};
    {in_ch.rate_x, in_ch.rate_y, in_ch.rate_z} <= {s.gx, s.gy, s.gz};
    do @(posedge clk); while (!in_ch.ready);
    pending_angles.push_back(update_attitude(s));
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 8)) - 16'sd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rnd_sample();
    sample_t s;
    s.ax = rnd16(); s.ay = rnd16(); s.az = rnd16();
    s.gx = rnd16(); s.gy = rnd16(); s.gz = rnd16();
    // Mostly a plausible attitude: small gyro rates; the accelerometer stays random.
    if ($urandom_range(0, 3) != 0) begin
      s.gx = 16'($signed($urandom_range(0, 400)) - 200);
      s.gy = 16'($signed($urandom_range(0, 400)) - 200);
      s.gz = 16'($signed($urandom_range(0, 400)) - 200);
    end
    return s;
  endfunction

  row_t rows[$];
  initial begin
    sample_t z;
    int burst;
    z = '0;
    in_ch.valid = 1'b0;
    {in_ch.accel_x, in_ch.accel_y, in_ch.accel_z} = '0;
    {in_ch.rate_x, in_ch.rate_y, in_ch.rate_z} = '0;
    roll_q = '0; pitch_q = '0; yaw_q = '0;
    weight_q = BlendReset[15:0];
    tilt_gain_q = TiltReset[23:0];
    head_gain_q = HeadReset[23:0];
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: zero vector at reset gives all zero angles.
    rows.push_back('{z, 1'b1, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd4000, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd4000, -16'sd4000, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, -16'sd4000, -16'sd4000, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sh7fff, 16'sh8000, 16'sd0, 16'sh7fff, 16'sh8000, 16'sh7fff},
                     1'b0, '0});
    rows.push_back('{'{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000},
                     1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, -16'sd1, 16'sd1, -16'sd1, 16'sd0}, 1'b0, '0});
    @(negedge clk);
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        void'(update_attitude(rows[i].s));
        pending_angles.push_back(rows[i].exp);
        in_ch.valid <= 1'b1;
        {in_ch.accel_x, in_ch.accel_y, in_ch.accel_z} <= '0;
        {in_ch.rate_x, in_ch.rate_y, in_ch.rate_z} <= '0;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
      end else send_sample(rows[i].s);
    end
    in_ch.valid <= 1'b0;
    wait_idle();

    // Extremes: zero weight means tilt alone; max gains give the largest yaw steps.
    write_reg(REG_BLEND, 24'd0);
    write_reg(REG_TILT, 24'hffffff);
    write_reg(REG_HEAD, 24'hffffff);
    for (int i = 0; i < 12; i++) send_sample('{16'sd100, -16'sd300, 16'sd0,
                                              16'sh7fff, 16'sh8000, 16'sh7fff});
    in_ch.valid <= 1'b0;
    wait_idle();
    write_reg(REG_BLEND, 24'hffffff);
    write_reg(REG_HEAD, 24'hffffff);
    for (int i = 0; i < 6; i++) send_sample('{16'sd0, 16'sd0, 16'sd0,
                                             16'sh8000, 16'sh7fff, 16'sh8000});
    in_ch.valid <= 1'b0;
    wait_idle();

    // Random phases with different settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_BLEND, BlendReset[23:0]);
          write_reg(REG_TILT, TiltReset[23:0]);
          write_reg(REG_HEAD, HeadReset[23:0]);
        end
        1: begin
          write_reg(REG_BLEND, 24'($urandom));
          write_reg(REG_TILT, 24'($urandom));
          write_reg(REG_HEAD, 24'($urandom));
        end
        2: begin
          write_reg(REG_BLEND, 24'd1);
          write_reg(REG_TILT, 24'd0);
          write_reg(REG_HEAD, 24'd1);
        end
        default: begin
          write_reg(REG_BLEND, 24'd65535);
          write_reg(REG_TILT, 24'($urandom_range(0, 4000000)));
          write_reg(REG_HEAD, 24'($urandom_range(0, 4000000)));
        end
      endcase
      if (ph == 1) long_hold = 1'b1;
      for (int n = 0; n < RandomItems / 4; ) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && n < RandomItems / 4; k++, n++)
          send_sample(rnd_sample());
        if ($urandom_range(0, 2) != 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 60)) @(negedge clk);
        end
        if (n == 100) begin
          in_ch.valid <= 1'b0;
          while (pending_angles.size() != 0) @(negedge clk);
        end
      end
      in_ch.valid <= 1'b0;
      wait_idle();
    end

    if (errors == 0) $display("tb_complementary_attitude_filter OK");
    else $display("tb_complementary_attitude_filter NOT OK");
    $finish;
  end

endmodule
